/* src/quaternion_rotate_vector_top_macros.svh */
// Assertion macros shared by the checker files of the rotation block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef QUATERNION_ROTATE_VECTOR_TOP_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_TOP_MACROS_SVH

// Property checked at every edge, reset included.
`define QRV_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("qrv check failed");

// Property checked outside reset only.
`define QRV_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrv check failed");

`endif

/* src/qrv_pkg.sv */
// Types, constants and arithmetic helpers of the quaternion rotation block.
// Used by the top level and its checker; depends on nothing.
package qrv_pkg;

  localparam int QW        = 32;
  localparam int FRAC      = 29;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;
  localparam int ACC_W     = 37;
  localparam int TRM_W     = 40;
  localparam int SUM_W     = 43;
  localparam int REG_W     = 30;

  localparam logic [REG_W-1:0] TOL_RST = 30'd537;
  localparam logic [REG_W-1:0] MIN_RST = 30'd0;
  localparam logic [QW-1:0]    ONE_Q   = 32'h2000_0000;

  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_IDENT,
    SEL_NORM
  } sel_t;

  typedef enum logic {
    REG_NORM_TOL = 1'b0,
    REG_MIN_NORM = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  function automatic logic [QW-1:0] mag32(logic signed [QW-1:0] x);
    logic [QW-1:0] m;
    m = x[QW-1] ? QW'(-x) : QW'(x);
    return m;
  endfunction

  // Round to nearest, ties up, dropping FRAC bits
  function automatic logic signed [ACC_W-1:0] rnd66(logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + (66'sd1 <<< (FRAC - 1));
    return t[65:FRAC];
  endfunction

  function automatic logic signed [TRM_W-1:0] rnd69(logic signed [68:0] x);
    logic signed [68:0] t;
    t = x + (69'sd1 <<< (FRAC - 1));
    return t[68:FRAC];
  endfunction

  function automatic logic signed [QW-1:0] sat32(logic signed [SUM_W-1:0] x);
    logic signed [QW-1:0] r;
    if (x > SUM_W'(32'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SUM_W'(-33'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[QW-1:0];
    end
    return r;
  endfunction

endpackage

/* src/quaternion_rotate_vector_top.sv */
// Accepts one transaction per cycle while in_stall is low.
// Path: norm squared (3 stages), 32-step square root, 32-step dividers, rotation (4 stages).
// A two-entry output queue lets the pipeline run on while one result waits.
// rst_n (synchronous) clears all valid bits and the queue; registers return to
// norm_tolerance 537, min_norm_squared 0.
// Top level of the quaternion rotation block; uses qrv_pkg.
module quaternion_rotate_vector_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qrv_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qrv_pkg::out_item_t   out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int SQN = qrv_pkg::SQ_STEPS;
  localparam int DVN = qrv_pkg::DIV_STEPS;

  // ---------------- configuration ----------------
  logic [qrv_pkg::REG_W-1:0] tol_r, min_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qrv_pkg::TOL_RST;
      min_r <= qrv_pkg::MIN_RST;
    end else if (cfg_wr) begin
      case (qrv_pkg::reg_idx_t'(cfg_paddr[2]))
        qrv_pkg::REG_NORM_TOL: tol_r <= cfg_pwdata[qrv_pkg::REG_W-1:0];
        qrv_pkg::REG_MIN_NORM: min_r <= cfg_pwdata[qrv_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (qrv_pkg::reg_idx_t'(cfg_paddr[2]))
      qrv_pkg::REG_NORM_TOL: cfg_prdata = 32'(tol_r);
      qrv_pkg::REG_MIN_NORM: cfg_prdata = 32'(min_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [1:0] cnt_r;
  logic       en;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = ~en;

  // ---------------- stage A: capture ----------------
  logic              a_vld_r;
  qrv_pkg::in_item_t a_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r <= in_data;
    end
  end

  // ---------------- stage B: squares ----------------
  logic              b_vld_r;
  qrv_pkg::in_item_t b_c_r;
  logic [61:0]       b_sq_r [0:3];
  logic [31:0]       a_mag  [0:3];
  logic [63:0]       a_prod [0:3];

  assign a_mag[0] = qrv_pkg::mag32(a_c_r.quat_w);
  assign a_mag[1] = qrv_pkg::mag32(a_c_r.quat_x);
  assign a_mag[2] = qrv_pkg::mag32(a_c_r.quat_y);
  assign a_mag[3] = qrv_pkg::mag32(a_c_r.quat_z);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_prod[k] = 64'(a_mag[k]) * 64'(a_mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_c_r <= a_c_r;
      for (int k = 0; k < 4; k++) begin
        b_sq_r[k] <= a_prod[k][63:2];
      end
    end
  end

  // ---------------- stage C: norm squared ----------------
  logic              c_vld_r;
  qrv_pkg::in_item_t c_c_r;
  logic [63:0]       c_s56_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_c_r   <= b_c_r;
      c_s56_r <= 64'(b_sq_r[0]) + 64'(b_sq_r[1]) + 64'(b_sq_r[2]) + 64'(b_sq_r[3]);
    end
  end

  // classify against unit norm
  logic [36:0]      c_n, c_dev;
  qrv_pkg::sel_t    c_sel;

  assign c_n   = c_s56_r[63:27];
  assign c_dev = (c_n >= 37'(qrv_pkg::ONE_Q)) ? c_n - 37'(qrv_pkg::ONE_Q)
                                              : 37'(qrv_pkg::ONE_Q) - c_n;

  always_comb begin
    if (c_dev <= 37'(tol_r)) begin
      c_sel = qrv_pkg::SEL_KEEP;
    end else if (c_n <= 37'(min_r)) begin
      c_sel = qrv_pkg::SEL_IDENT;
    end else begin
      c_sel = qrv_pkg::SEL_NORM;
    end
  end

  // ---------------- square root stages ----------------
  logic              sq_vld_r [0:SQN];
  qrv_pkg::in_item_t sq_c_r   [0:SQN];
  qrv_pkg::sel_t     sq_sel_r [0:SQN];
  logic [63:0]       sq_v_r   [0:SQN];
  logic [63:0]       sq_r_r   [0:SQN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c_r[0]   <= c_c_r;
      sq_sel_r[0] <= c_sel;
      sq_v_r[0]   <= c_s56_r;
      sq_r_r[0]   <= '0;
    end
  end

  for (genvar i = 1; i <= SQN; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (i - 1));
    logic [63:0] trial;
    logic        ge;

    assign trial = sq_r_r[i-1] + BIT;
    assign ge    = (sq_v_r[i-1] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i] <= 1'b0;
      end else if (en) begin
        sq_vld_r[i] <= sq_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c_r[i]   <= sq_c_r[i-1];
        sq_sel_r[i] <= sq_sel_r[i-1];
        sq_v_r[i]   <= ge ? sq_v_r[i-1] - trial : sq_v_r[i-1];
        sq_r_r[i]   <= ge ? (sq_r_r[i-1] >> 1) + BIT : sq_r_r[i-1] >> 1;
      end
    end
  end

  // ---------------- divider stages ----------------
  logic              dv_vld_r [0:DVN];
  qrv_pkg::in_item_t dv_c_r   [0:DVN];
  qrv_pkg::sel_t     dv_sel_r [0:DVN];
  logic [31:0]       dv_div_r [0:DVN];
  logic [31:0]       dv_rem_r [0:DVN][0:3];
  logic [31:0]       dv_low_r [0:DVN][0:3];
  logic [31:0]       dv_quo_r [0:DVN][0:3];

  logic [31:0] sq_root;
  logic [31:0] sq_mag  [0:3];
  logic [59:0] sq_dend [0:3];

  assign sq_root   = sq_r_r[SQN][31:0];
  assign sq_mag[0] = qrv_pkg::mag32(sq_c_r[SQN].quat_w);
  assign sq_mag[1] = qrv_pkg::mag32(sq_c_r[SQN].quat_x);
  assign sq_mag[2] = qrv_pkg::mag32(sq_c_r[SQN].quat_y);
  assign sq_mag[3] = qrv_pkg::mag32(sq_c_r[SQN].quat_z);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq_dend[k] = {sq_mag[k], 28'd0} + 60'(sq_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c_r[0]   <= sq_c_r[SQN];
      dv_sel_r[0] <= sq_sel_r[SQN];
      dv_div_r[0] <= sq_root;
      for (int k = 0; k < 4; k++) begin
        dv_rem_r[0][k] <= 32'(sq_dend[k][59:32]);
        dv_low_r[0][k] <= sq_dend[k][31:0];
        dv_quo_r[0][k] <= '0;
      end
    end
  end

  for (genvar i = 1; i <= DVN; i++) begin : g_div
    logic [32:0] part [0:3];
    logic [32:0] diff [0:3];
    logic        ge   [0:3];

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        part[k] = {dv_rem_r[i-1][k], dv_low_r[i-1][k][31]};
        diff[k] = part[k] - {1'b0, dv_div_r[i-1]};
        ge[k]   = (part[k] >= {1'b0, dv_div_r[i-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[i] <= 1'b0;
      end else if (en) begin
        dv_vld_r[i] <= dv_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c_r[i]   <= dv_c_r[i-1];
        dv_sel_r[i] <= dv_sel_r[i-1];
        dv_div_r[i] <= dv_div_r[i-1];
        for (int k = 0; k < 4; k++) begin
          dv_rem_r[i][k] <= ge[k] ? diff[k][31:0] : part[k][31:0];
          dv_low_r[i][k] <= {dv_low_r[i-1][k][30:0], 1'b0};
          dv_quo_r[i][k] <= {dv_quo_r[i-1][k][30:0], ge[k]};
        end
      end
    end
  end

  // ---------------- stage Q: pick the quaternion ----------------
  logic               qs_vld_r;
  logic               qs_mode_r;
  logic signed [31:0] qs_q_r [0:3];
  logic signed [31:0] qs_v_r [0:2];
  logic signed [31:0] dv_orig [0:3];
  logic signed [31:0] qs_nxt  [0:3];

  assign dv_orig[0] = dv_c_r[DVN].quat_w;
  assign dv_orig[1] = dv_c_r[DVN].quat_x;
  assign dv_orig[2] = dv_c_r[DVN].quat_y;
  assign dv_orig[3] = dv_c_r[DVN].quat_z;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (dv_sel_r[DVN])
        qrv_pkg::SEL_KEEP:  qs_nxt[k] = dv_orig[k];
        qrv_pkg::SEL_IDENT: qs_nxt[k] = (k == 0) ? $signed(qrv_pkg::ONE_Q) : 32'sd0;
        qrv_pkg::SEL_NORM:  qs_nxt[k] = dv_orig[k][31] ? -$signed(dv_quo_r[DVN][k])
                                                       : $signed(dv_quo_r[DVN][k]);
        default:            qs_nxt[k] = dv_orig[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_vld_r <= 1'b0;
    end else if (en) begin
      qs_vld_r <= dv_vld_r[DVN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs_mode_r <= dv_c_r[DVN].mode;
      for (int k = 0; k < 4; k++) begin
        qs_q_r[k] <= qs_nxt[k];
      end
      qs_v_r[0] <= dv_c_r[DVN].vec_x;
      qs_v_r[1] <= dv_c_r[DVN].vec_y;
      qs_v_r[2] <= dv_c_r[DVN].vec_z;
    end
  end

  // ---------------- stage R1: first products ----------------
  logic               m1_vld_r, m1_mode_r;
  logic signed [31:0] m1_q_r  [0:3];
  logic signed [31:0] m1_v_r  [0:2];
  logic signed [63:0] m1_sq_r [0:3];
  logic signed [63:0] m1_dp_r [0:2];
  logic signed [63:0] m1_cp_r [0:5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= qs_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mode_r <= qs_mode_r;
      m1_q_r    <= qs_q_r;
      m1_v_r    <= qs_v_r;
      for (int k = 0; k < 4; k++) begin
        m1_sq_r[k] <= qs_q_r[k] * qs_q_r[k];
      end
      for (int k = 0; k < 3; k++) begin
        m1_dp_r[k] <= qs_q_r[k+1] * qs_v_r[k];
      end
      // cross product terms: y*vz, z*vy, z*vx, x*vz, x*vy, y*vx
      m1_cp_r[0] <= qs_q_r[2] * qs_v_r[2];
      m1_cp_r[1] <= qs_q_r[3] * qs_v_r[1];
      m1_cp_r[2] <= qs_q_r[3] * qs_v_r[0];
      m1_cp_r[3] <= qs_q_r[1] * qs_v_r[2];
      m1_cp_r[4] <= qs_q_r[1] * qs_v_r[1];
      m1_cp_r[5] <= qs_q_r[2] * qs_v_r[0];
    end
  end

  // ---------------- stage R2: sums and rounding ----------------
  logic                          m2_vld_r, m2_mode_r;
  logic signed [31:0]            m2_q_r [0:3];
  logic signed [31:0]            m2_v_r [0:2];
  logic signed [qrv_pkg::ACC_W-1:0] m2_a_r, m2_d_r;
  logic signed [qrv_pkg::ACC_W-1:0] m2_c_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_mode_r <= m1_mode_r;
      m2_q_r    <= m1_q_r;
      m2_v_r    <= m1_v_r;
      m2_a_r    <= qrv_pkg::rnd66(66'(m1_sq_r[0]) - 66'(m1_sq_r[1])
                                  - 66'(m1_sq_r[2]) - 66'(m1_sq_r[3]));
      m2_d_r    <= qrv_pkg::rnd66(66'(m1_dp_r[0]) + 66'(m1_dp_r[1]) + 66'(m1_dp_r[2]));
      m2_c_r[0] <= qrv_pkg::rnd66(66'(m1_cp_r[0]) - 66'(m1_cp_r[1]));
      m2_c_r[1] <= qrv_pkg::rnd66(66'(m1_cp_r[2]) - 66'(m1_cp_r[3]));
      m2_c_r[2] <= qrv_pkg::rnd66(66'(m1_cp_r[4]) - 66'(m1_cp_r[5]));
    end
  end

  // ---------------- stage R3: second products ----------------
  logic               m3_vld_r, m3_mode_r;
  logic signed [68:0] m3_t1_r [0:2];
  logic signed [68:0] m3_t2_r [0:2];
  logic signed [68:0] m3_t3_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_mode_r <= m2_mode_r;
      for (int k = 0; k < 3; k++) begin
        m3_t1_r[k] <= m2_a_r * m2_v_r[k];
        m3_t2_r[k] <= m2_d_r * m2_q_r[k+1];
        m3_t3_r[k] <= m2_q_r[0] * m2_c_r[k];
      end
    end
  end

  // ---------------- final sum and saturation ----------------
  logic signed [qrv_pkg::TRM_W-1:0] f_t1 [0:2];
  logic signed [qrv_pkg::TRM_W-1:0] f_t2 [0:2];
  logic signed [qrv_pkg::TRM_W-1:0] f_t3 [0:2];
  logic signed [qrv_pkg::SUM_W-1:0] f_sum [0:2];
  qrv_pkg::out_item_t               push_data;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_t1[k] = qrv_pkg::rnd69(m3_t1_r[k]);
      f_t2[k] = qrv_pkg::rnd69(m3_t2_r[k]);
      f_t3[k] = qrv_pkg::rnd69(m3_t3_r[k]);
      if (m3_mode_r) begin
        f_sum[k] = qrv_pkg::SUM_W'(f_t1[k]) + (qrv_pkg::SUM_W'(f_t2[k]) <<< 1)
                   - (qrv_pkg::SUM_W'(f_t3[k]) <<< 1);
      end else begin
        f_sum[k] = qrv_pkg::SUM_W'(f_t1[k]) + (qrv_pkg::SUM_W'(f_t2[k]) <<< 1)
                   + (qrv_pkg::SUM_W'(f_t3[k]) <<< 1);
      end
    end
    push_data.out_x = qrv_pkg::sat32(f_sum[0]);
    push_data.out_y = qrv_pkg::sat32(f_sum[1]);
    push_data.out_z = qrv_pkg::sat32(f_sum[2]);
  end

  // ---------------- output queue ----------------
  qrv_pkg::out_item_t slot0_r, slot1_r;
  logic               push, pop;

  assign push      = en & m3_vld_r;
  assign pop       = out_valid & ~out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if ((cnt_r == 2'd0 && push) || (pop && cnt_r == 2'd1 && push)) begin
      slot0_r <= push_data;
    end else if (pop && cnt_r == 2'd2) begin
      slot0_r <= slot1_r;
    end
    if (push && ((cnt_r == 2'd1 && !pop) || (cnt_r == 2'd2 && pop))) begin
      slot1_r <= push_data;
    end
  end

endmodule

/* src/qrv_check.sv */
// Port-level checker for the quaternion rotation block, bound to the top level.
// Uses qrv_pkg and the macros in quaternion_rotate_vector_top_macros.svh.
`include "quaternion_rotate_vector_top_macros.svh"

module qrv_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input qrv_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input qrv_pkg::out_item_t out_data,
  input logic               cfg_psel,
  input logic               cfg_penable,
  input logic               cfg_pwrite,
  input logic [2:0]         cfg_paddr,
  input logic [31:0]        cfg_pwdata,
  input logic [31:0]        cfg_prdata,
  input logic               cfg_pready
);

  // a held result stays put
  `QRV_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

  // reset leaves no result pending
  `QRV_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)

  // input backpressure only while a result is waiting
  `QRV_ASSERT_RUN(a_stall_needs_out, in_stall |-> out_valid)

  // the queue fills only when the consumer held the head
  `QRV_ASSERT_RUN(a_stall_rise, $rose(in_stall) |-> $past(out_valid && out_stall))

  // the register port never waits
  `QRV_ASSERT_RUN(a_pready, cfg_psel |-> cfg_pready)

endmodule

bind quaternion_rotate_vector_top qrv_check u_qrv_check (.*);

/* bench/qrv_rotation_checker.sv */
// Checker for the quaternion rotation block: watches both channels and the APB port,
// computes each expected rotated vector and compares it. Depends on qrv_pkg.
module qrv_rotation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  qrv_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  qrv_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  localparam logic [2:0] ADDR_NORM_TOL = 3'(4 * qrv_pkg::REG_NORM_TOL);
  localparam logic [2:0] ADDR_MIN_NORM = 3'(4 * qrv_pkg::REG_MIN_NORM);
  localparam wide_t      SAT_HI        = (wide_t'(1) <<< 31) - wide_t'(1);
  localparam wide_t      SAT_LO        = -(wide_t'(1) <<< 31);

  logic [29:0]        tol_q;
  logic [29:0]        min_q;
  qrv_pkg::out_item_t rotated_q[$];

  function automatic wide_t rnd29(wide_t x);
    return (x + (wide_t'(1) <<< 28)) >>> 29;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic qrv_pkg::out_item_t rotate_vec(qrv_pkg::in_item_t it, logic [29:0] tol,
                                                    logic [29:0] mn);
    wide_t              q[4];
    wide_t              v[3];
    wide_t              c[3];
    wide_t              a, d, n, dev, t1, t2, t3, s;
    logic [63:0]        s56, m, r;
    qrv_pkg::out_item_t o;
    q[0] = it.quat_w; q[1] = it.quat_x; q[2] = it.quat_y; q[3] = it.quat_z;
    v[0] = it.vec_x;  v[1] = it.vec_y;  v[2] = it.vec_z;
    s56 = '0;
    for (int i = 0; i < 4; i++) begin
      m = q[i] < 0 ? 64'(-q[i]) : 64'(q[i]);
      s56 += (m * m) >> 2;
    end
    n = wide_t'(s56 >> 27);
    dev = n - (wide_t'(1) <<< 29);
    if (dev < 0) dev = -dev;
    if (dev > wide_t'(tol)) begin
      if (n <= wide_t'(mn)) begin
        q[0] = wide_t'(1) <<< 29;
        q[1] = 0; q[2] = 0; q[3] = 0;
      end else begin
        r = isqrt64(s56);
        for (int i = 0; i < 4; i++) begin
          m = q[i] < 0 ? 64'(-q[i]) : 64'(q[i]);
          m = ((m << 28) + (r >> 1)) / r;
          q[i] = q[i] < 0 ? -wide_t'(m) : wide_t'(m);
        end
      end
    end
    a = rnd29(q[0] * q[0] - q[1] * q[1] - q[2] * q[2] - q[3] * q[3]);
    d = rnd29(q[1] * v[0] + q[2] * v[1] + q[3] * v[2]);
    c[0] = rnd29(q[2] * v[2] - q[3] * v[1]);
    c[1] = rnd29(q[3] * v[0] - q[1] * v[2]);
    c[2] = rnd29(q[1] * v[1] - q[2] * v[0]);
    for (int i = 0; i < 3; i++) begin
      t1 = rnd29(a * v[i]);
      t2 = rnd29(d * q[1 + i]);
      t3 = rnd29(q[0] * c[i]);
      s = it.mode ? t1 + 2 * t2 - 2 * t3 : t1 + 2 * t2 + 2 * t3;
      if (s > SAT_HI) s = SAT_HI;
      if (s < SAT_LO) s = SAT_LO;
      case (i)
        0: o.out_x = s[31:0];
        1: o.out_y = s[31:0];
        default: o.out_z = s[31:0];
      endcase
    end
    return o;
  endfunction

  initial begin
    errors = 0;
    tol_q = qrv_pkg::TOL_RST;
    min_q = qrv_pkg::MIN_RST;
  end

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    qrv_pkg::out_item_t exp_o;
    if (!rst_n) begin
      rotated_q.delete();
      tol_q <= qrv_pkg::TOL_RST;
      min_q <= qrv_pkg::MIN_RST;
    end else begin
      if (in_valid && !in_stall) rotated_q.push_back(rotate_vec(in_data, tol_q, min_q));
      if (out_valid && !out_stall) begin
        if (rotated_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          exp_o = rotated_q.pop_front();
          if (out_data.out_x !== exp_o.out_x) begin
            errors++;
            $display("%0t: out_x expected %h actual %h", $time, exp_o.out_x, out_data.out_x);
          end
          if (out_data.out_y !== exp_o.out_y) begin
            errors++;
            $display("%0t: out_y expected %h actual %h", $time, exp_o.out_y, out_data.out_y);
          end
          if (out_data.out_z !== exp_o.out_z) begin
            errors++;
            $display("%0t: out_z expected %h actual %h", $time, exp_o.out_z, out_data.out_z);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_NORM_TOL) tol_q <= cfg_pwdata[29:0];
        else if (cfg_paddr == ADDR_MIN_NORM) min_q <= cfg_pwdata[29:0];
      end
    end
  end

endmodule

/* bench/quaternion_rotate_vector_top_tb.sv */
// Testbench top for the quaternion rotation block: clock, reset, stimulus and verdict.
// Depends on qrv_pkg, quaternion_rotate_vector_top and qrv_rotation_checker.
module quaternion_rotate_vector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic signed [31:0] UNIT = 32'sh2000_0000;
  localparam logic signed [31:0] DIAG = 32'sd379625062;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  qrv_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  qrv_pkg::out_item_t out_data;
  logic               cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata, cfg_prdata;
  int                 errors;
  int                 pending;
  int                 idle_cycles;
  bit                 calm;
  bit                 hold_req;

  quaternion_rotate_vector_top i_dut (.*);

  qrv_rotation_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: any transaction on any port resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quaternion_rotate_vector_top verification failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold on request, none once calm
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk);
      end else if (calm || $urandom_range(3) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(qrv_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * idx);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_item(qrv_pkg::in_item_t it, bit gaps);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (gaps && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic qrv_pkg::in_item_t make_item(logic m, logic signed [31:0] w,
                                                  logic signed [31:0] x,
                                                  logic signed [31:0] y, logic signed [31:0] z,
                                                  logic signed [31:0] vx, logic signed [31:0] vy,
                                                  logic signed [31:0] vz);
    qrv_pkg::in_item_t it;
    it.mode = m;
    it.quat_w = w; it.quat_x = x; it.quat_y = y; it.quat_z = z;
    it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_comp(int span);
    logic signed [31:0] r;
    r = $urandom;
    return span >= 31 ? r : (r >>> (31 - span));
  endfunction

  function automatic qrv_pkg::in_item_t random_item();
    qrv_pkg::in_item_t it;
    int kind;
    int qs, vs;
    kind = $urandom_range(9);
    qs = kind < 3 ? 31 : (kind < 6 ? $urandom_range(4, 30) : 29);
    vs = kind == 0 ? 31 : $urandom_range(4, 31);
    it.mode = 1'($urandom);
    it.quat_w = pick_comp(qs); it.quat_x = pick_comp(qs);
    it.quat_y = pick_comp(qs); it.quat_z = pick_comp(qs);
    // Near-unit quaternions: w is UNIT, randomly signed, with small random x, y and z
    if (kind == 9) begin
      it.quat_w = $urandom_range(1) ? UNIT : -UNIT;
      it.quat_x = $urandom_range(200) - 100;
      it.quat_y = $urandom_range(200) - 100;
      it.quat_z = $urandom_range(200) - 100;
    end
    it.vec_x = pick_comp(vs); it.vec_y = pick_comp(vs); it.vec_z = pick_comp(vs);
    return it;
  endfunction

  task automatic random_run(int count, bit gaps);
    for (int i = 0; i < count; i++) send_item(random_item(), gaps);
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero and extreme quaternions, extreme vectors, both modes
    send_item(make_item(0, UNIT, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0), 1);
    send_item(make_item(1, UNIT, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, -1), 1);
    send_item(make_item(0, 0, 0, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000), 1);
    send_item(make_item(0, DIAG, DIAG, 0, 0, 0, 32'sh0001_0000, 0), 1);
    send_item(make_item(1, DIAG, DIAG, 0, 0, 0, 32'sh0001_0000, 0), 1);
    send_item(make_item(0, DIAG, 0, 0, -DIAG, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0), 1);
    send_item(make_item(0, 0, UNIT, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1);
    send_item(make_item(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000), 1);
    send_item(make_item(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 0, 32'sh8000_0000), 1);
    send_item(make_item(0, 32'sh8000_0000, 0, 0, 0, 32'sh0001_0000, 0, 0), 1);
    send_item(make_item(1, 1, 0, 0, -1, 32'sh0001_0000, -32'sh0001_0000, 5), 1);
    send_item(make_item(0, UNIT + 537, 0, 0, 0, 32'sh0010_0000, 7, -7), 1);
    send_item(make_item(0, UNIT + 2000, 0, 0, 0, 32'sh0010_0000, 7, -7), 1);
    send_item(make_item(1, UNIT - 2000, 5, -5, 3, 32'sh7FFF_FFFF, 1, 32'sh8000_0000), 1);
    send_item(make_item(0, 32'sh0000_8000, 32'sh0000_8000, 0, 0, 1, 1, 1), 1);
    send_item(make_item(1, 0, 0, -UNIT, 0, 32'sh1234_5678, -32'sh0765_4321, 3), 1);
    drain();

    write_reg(qrv_pkg::REG_NORM_TOL, 32'd0);
    write_reg(qrv_pkg::REG_MIN_NORM, 32'd0);
    send_item(make_item(0, UNIT + 1, 0, 0, 0, 32'sh0001_0000, 3, 4), 1);
    send_item(make_item(1, 0, 0, 0, 0, 32'sh7FFF_FFFF, 3, 4), 1);
    random_run(250, 1);
    drain();

    // Long receiver hold: the block must fill up and stall its input
    hold_req = 1'b1;
    write_reg(qrv_pkg::REG_NORM_TOL, 32'd536870912);
    write_reg(qrv_pkg::REG_MIN_NORM, 32'd536870912);
    random_run(300, 0);
    drain();

    write_reg(qrv_pkg::REG_NORM_TOL, 32'd537);
    write_reg(qrv_pkg::REG_MIN_NORM, 32'd536870912);
    random_run(250, 1);
    drain();

    write_reg(qrv_pkg::REG_NORM_TOL, 32'hFFFF_FFFF);
    write_reg(qrv_pkg::REG_MIN_NORM, 32'hFFFF_FFFF);
    random_run(150, 1);
    drain();

    write_reg(qrv_pkg::REG_NORM_TOL, $urandom_range(0, 536870912));
    write_reg(qrv_pkg::REG_MIN_NORM, $urandom_range(0, 536870912));
    random_run(300, 1);
    drain();

    write_reg(qrv_pkg::REG_NORM_TOL, 32'd537);
    write_reg(qrv_pkg::REG_MIN_NORM, $urandom_range(0, 1 << 20));
    random_run(200, 1);
    calm = 1'b1;
    random_run(250, 0);
    drain();

    if (errors == 0) begin
      $display("quaternion_rotate_vector_top verification clean");
    end else begin
      $display("quaternion_rotate_vector_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/qrv_pkg.sv
src/quaternion_rotate_vector_top.sv
src/qrv_check.sv
bench/qrv_rotation_checker.sv
bench/quaternion_rotate_vector_top_tb.sv
